FILE: rtl/core/wra_pkg.sv
// ----------------------------------------------------------------------------
// wra_pkg
// Shared constants and types for the wraparound range ALU: operation and
// status codes, intermediate width and the divider request bundle.
// ----------------------------------------------------------------------------
package wra_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int X_WIDTH             = 64;   // exact intermediate result
  localparam int ITER_WIDTH          = 7;    // divider step counter, holds X_WIDTH
  localparam int FIELD_WIDTH         = 32;
  localparam int CFG_INDEX_WIDTH     = 4;
  localparam int RESET_LOW           = 1;
  localparam int RESET_HIGH          = 12;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 4'd1;

  // operation codes
  localparam logic [4:0] OP_LOAD  = 5'd0;
  localparam logic [4:0] OP_ADD   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_RSUB  = 5'd3;
  localparam logic [4:0] OP_MUL   = 5'd4;
  localparam logic [4:0] OP_DIV   = 5'd5;
  localparam logic [4:0] OP_RDIV  = 5'd6;
  localparam logic [4:0] OP_MOD   = 5'd7;
  localparam logic [4:0] OP_AND   = 5'd8;
  localparam logic [4:0] OP_OR    = 5'd9;
  localparam logic [4:0] OP_XOR   = 5'd10;
  localparam logic [4:0] OP_SHL   = 5'd11;
  localparam logic [4:0] OP_SHR   = 5'd12;
  localparam logic [4:0] OP_NEG   = 5'd13;
  localparam logic [4:0] OP_NOT   = 5'd14;
  localparam logic [4:0] OP_INC   = 5'd15;
  localparam logic [4:0] OP_DEC   = 5'd16;
  localparam logic [4:0] OP_QUERY = 5'd17;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INEXACT  = 3'd1;
  localparam logic [2:0] ST_DIVZERO  = 3'd2;
  localparam logic [2:0] ST_BADRANGE = 3'd3;
  localparam logic [2:0] ST_SHIFT    = 3'd4;

  // comparison codes
  localparam logic [1:0] CMP_LESS    = 2'd0;
  localparam logic [1:0] CMP_EQUAL   = 2'd1;
  localparam logic [1:0] CMP_GREATER = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [ITER_WIDTH-1:0] iters;
  } div_req_t;

endpackage

FILE: rtl/core/wra_div.sv
// ----------------------------------------------------------------------------
// wra_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// left aligned; iters gives how many of its top bits take part.
// ----------------------------------------------------------------------------
module wra_div #(
  parameter int VALUE_WIDTH = wra_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wra_pkg::div_req_t              req,
  input  logic [wra_pkg::X_WIDTH-1:0]    dividend,
  input  logic [VALUE_WIDTH:0]           divisor,
  output logic                           done,
  output logic [wra_pkg::X_WIDTH-1:0]    quotient,
  output logic [VALUE_WIDTH:0]           remainder
);
  import wra_pkg::*;

  localparam int W = VALUE_WIDTH;

  logic [X_WIDTH-1:0]    quo;
  logic [W:0]            rem;
  logic [W:0]            dsr;
  logic [ITER_WIDTH-1:0] cnt;
  logic                  busy;
  logic [W+1:0]          shifted;
  logic [W+1:0]          trial;

  assign shifted = {rem, quo[X_WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      quo  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      cnt  <= req.iters;
    end else if (busy) begin
      if (!trial[W+1]) begin
        rem <= trial[W:0];
        quo <= {quo[X_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[W:0];
        quo <= {quo[X_WIDTH-2:0], 1'b0};
      end
      cnt <= cnt - ITER_WIDTH'(1);
      if (cnt == ITER_WIDTH'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/core/wraparound_range_alu_top.sv
// ----------------------------------------------------------------------------
// wraparound_range_alu_top
// Accumulator ALU whose results wrap into [range_low, range_high].
// Flow: one request at a time (in_ready only in S_IDLE); div, rdiv and mod
//   run an operand division pass before the range reduction.
// Pacing: a new request waits until the result leaves S_DONE; the wait is set
//   by the shared bit-serial divider (64 steps for the range reduction).
// Reset: synchronous rst; range 1..12, accumulator 1, no result pending.
// ----------------------------------------------------------------------------
module wraparound_range_alu_top #(
  parameter int VALUE_WIDTH = wra_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [wra_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [wra_pkg::FIELD_WIDTH-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [4:0]                          operation,
  input  logic signed [wra_pkg::FIELD_WIDTH-1:0] operand,
  input  logic                                commit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wra_pkg::FIELD_WIDTH-1:0] value,
  output logic signed [wra_pkg::FIELD_WIDTH-1:0] previous,
  output logic [2:0]                          status,
  output logic [1:0]                          comparison,
  output logic                                at_minimum
);
  import wra_pkg::*;

  localparam int W = VALUE_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CALC   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_RSTART = 3'd3;
  localparam logic [2:0] S_RED    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]              state;
  logic signed [W-1:0]     range_low;
  logic signed [W-1:0]     range_high;
  logic signed [W-1:0]     acc;
  logic [4:0]              op_r;
  logic signed [W-1:0]     b_r;
  logic                    commit_r;
  logic signed [X_WIDTH-1:0] x_r;
  logic [2:0]              st_r;
  logic signed [W-1:0]     res_r;
  logic                    red_neg;

  logic signed [X_WIDTH-1:0] a64;
  logic signed [X_WIDTH-1:0] b64;
  logic signed [2*W-1:0]   prod;
  logic [W-1:0]            a_mag;
  logic [W-1:0]            b_mag;
  logic                    shift_bad;
  logic                    bad_range;
  logic signed [X_WIDTH-1:0] x_calc;
  logic [2:0]              st_calc;
  logic                    div_go;
  logic [W-1:0]            dv_mag;
  logic [W-1:0]            ds_mag;

  logic signed [X_WIDTH-1:0] d;
  logic [X_WIDTH-1:0]      d_mag;
  logic [W:0]              modulus;
  logic [W:0]              r_adj;
  logic [W+1:0]            v_sum;
  logic signed [X_WIDTH-1:0] q_signed;
  logic signed [X_WIDTH-1:0] r_signed;

  div_req_t                div_req;
  logic [X_WIDTH-1:0]      div_dividend;
  logic [W:0]              div_divisor;
  logic                    div_done;
  logic [X_WIDTH-1:0]      div_quo;
  logic [W:0]              div_rem;

  assign in_ready = (state == S_IDLE);

  assign a64       = X_WIDTH'(acc);
  assign b64       = X_WIDTH'(b_r);
  assign prod      = acc * b_r;
  assign a_mag     = acc[W-1] ? W'(-acc) : W'(acc);
  assign b_mag     = b_r[W-1] ? W'(-b_r) : W'(b_r);
  assign shift_bad = b_r[W-1] | (|b_r[W-2:5]);
  assign bad_range = (range_high < range_low);

  always_comb begin
    x_calc  = a64;
    st_calc = ST_OK;
    div_go  = 1'b0;
    dv_mag  = a_mag;
    ds_mag  = b_mag;
    unique case (op_r) inside
      OP_LOAD: x_calc = b64;
      OP_ADD:  x_calc = a64 + b64;
      OP_SUB:  x_calc = a64 - b64;
      OP_RSUB: x_calc = b64 - a64;
      OP_MUL:  x_calc = X_WIDTH'(prod);
      OP_DIV, OP_MOD: begin
        div_go = 1'b1;
        if (b_r == '0) st_calc = ST_DIVZERO;
      end
      OP_RDIV: begin
        div_go = 1'b1;
        dv_mag = b_mag;
        ds_mag = a_mag;
        if (acc == '0) st_calc = ST_DIVZERO;
      end
      OP_AND:  x_calc = a64 & b64;
      OP_OR:   x_calc = a64 | b64;
      OP_XOR:  x_calc = a64 ^ b64;
      OP_SHL: begin
        if (shift_bad) st_calc = ST_SHIFT;
        else x_calc = a64 <<< b_r[4:0];
      end
      OP_SHR: begin
        if (shift_bad) st_calc = ST_SHIFT;
        else x_calc = a64 >>> b_r[4:0];
      end
      OP_NEG:  x_calc = -a64;
      OP_NOT:  x_calc = ~a64;
      OP_INC:  x_calc = a64 + X_WIDTH'(1);
      OP_DEC:  x_calc = a64 - X_WIDTH'(1);
      default: x_calc = a64;
    endcase
    if (bad_range) st_calc = ST_BADRANGE;
  end

  // range reduction operands
  assign d       = x_r - X_WIDTH'(range_low);
  assign d_mag   = d[X_WIDTH-1] ? X_WIDTH'(-d) : X_WIDTH'(d);
  assign modulus = {range_high[W-1], range_high} - {range_low[W-1], range_low}
                   + (W+1)'(1);
  // negative offsets fold back from the top of the range
  assign r_adj   = (red_neg && div_rem != '0) ? modulus - div_rem : div_rem;
  assign v_sum   = {range_low[W-1], range_low[W-1], range_low} + {1'b0, r_adj};

  // signed quotient and truncated remainder from the operand pass
  always_comb begin
    if (op_r == OP_RDIV) begin
      q_signed = (b_r[W-1] ^ acc[W-1]) ? -X_WIDTH'(div_quo) : X_WIDTH'(div_quo);
    end else begin
      q_signed = (acc[W-1] ^ b_r[W-1]) ? -X_WIDTH'(div_quo) : X_WIDTH'(div_quo);
    end
    r_signed = acc[W-1] ? -X_WIDTH'(div_rem) : X_WIDTH'(div_rem);
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = ITER_WIDTH'(X_WIDTH);
    div_dividend  = d_mag;
    div_divisor   = modulus;
    if (state == S_CALC) begin
      div_req.start = div_go && (st_calc == ST_OK);
      div_req.iters = ITER_WIDTH'(W);
      div_dividend  = {dv_mag, {(X_WIDTH-W){1'b0}}};
      div_divisor   = {1'b0, ds_mag};
    end else if (state == S_RSTART) begin
      div_req.start = 1'b1;
    end
  end

  wra_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      range_low  <= W'(RESET_LOW);
      range_high <= W'(RESET_HIGH);
      acc        <= W'(RESET_LOW);
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= operation;
            b_r      <= operand[W-1:0];
            commit_r <= commit;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          st_r  <= st_calc;
          x_r   <= x_calc;
          res_r <= acc;
          if (st_calc != ST_OK) state <= S_DONE;
          else if (div_go) state <= S_DIV;
          else state <= S_RSTART;
        end
        S_DIV: begin
          if (div_done) begin
            if (op_r == OP_MOD) begin
              x_r   <= r_signed;
              state <= S_RSTART;
            end else if (div_rem != '0) begin
              st_r  <= ST_INEXACT;
              state <= S_DONE;
            end else begin
              x_r   <= q_signed;
              state <= S_RSTART;
            end
          end
        end
        S_RSTART: begin
          red_neg <= d[X_WIDTH-1];
          state   <= S_RED;
        end
        S_RED: begin
          if (div_done) begin
            res_r <= v_sum[W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            value      <= FIELD_WIDTH'(res_r);
            previous   <= FIELD_WIDTH'(acc);
            status     <= st_r;
            at_minimum <= (acc == range_low);
            if (acc < b_r) comparison <= CMP_LESS;
            else if (acc == b_r) comparison <= CMP_EQUAL;
            else comparison <= CMP_GREATER;
            if (st_r == ST_OK && commit_r) acc <= res_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // configuration must be written only while idle; the block does not enforce it
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RANGE_LOW: begin
            range_low <= cfg_data[W-1:0];
            acc       <= cfg_data[W-1:0];
          end
          REG_RANGE_HIGH: range_high <= cfg_data[W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
